FILE: hdl/mhpq_pkg.sv
// Shared constants and types for the binary max-heap priority queue.
// No dependencies; used by the interfaces and by every mhpq module except mhpq_ram.
package mhpq_pkg;

  localparam int unsigned CAPACITY_DEF = 255;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned COUNT_W      = 8;

  // request codes
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [KEY_W-1:0] key_out;
    logic [STATUS_W-1:0]     status;
    logic [COUNT_W-1:0]      count_after;
  } result_t;

endpackage

FILE: hdl/mhpq_req_if.sv
// Request channel: valid/ready handshake with push/pop code and key.
// Depends on mhpq_pkg.
interface mhpq_req_if;
  logic                               valid;
  logic                               ready;
  logic                               req_type;
  logic signed [mhpq_pkg::KEY_W-1:0]  key_in;

  modport source (output valid, output req_type, output key_in, input ready);
  modport sink   (input valid, input req_type, input key_in, output ready);
endinterface

FILE: hdl/mhpq_rsp_if.sv
// Response channel: valid/ready handshake with popped key, status and count.
// Depends on mhpq_pkg.
interface mhpq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [mhpq_pkg::KEY_W-1:0]   key_out;
  logic [mhpq_pkg::STATUS_W-1:0]       status;
  logic [mhpq_pkg::COUNT_W-1:0]        count_after;

  modport source (output valid, output key_out, output status, output count_after,
                  input ready);
  modport sink   (input valid, input key_out, input status, input count_after,
                  output ready);
endinterface

FILE: hdl/mhpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mhpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/mhpq_cmp.sv
// Shared signed key comparator (strictly greater than).
// Depends on mhpq_pkg.
module mhpq_cmp (
  input  logic signed [mhpq_pkg::KEY_W-1:0] a_i,
  input  logic signed [mhpq_pkg::KEY_W-1:0] b_i,
  output logic                              gt_o
);

  assign gt_o = (a_i > b_i);

endmodule

FILE: hdl/mhpq_seq.sv
// Heap sequencer: sift-up for push, sift-down for pop, one RAM access per cycle.
// Depends on mhpq_pkg, mhpq_ram and mhpq_cmp.
module mhpq_seq #(
  parameter int unsigned CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_valid_i,
  output logic                              req_ready_o,
  input  logic                              req_type_i,
  input  logic signed [mhpq_pkg::KEY_W-1:0] key_in_i,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output mhpq_pkg::result_t                 res_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned KW    = mhpq_pkg::KEY_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ROOT    = CNT_W'(1);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_SU_RD  = 11'b000_0000_0010,
    ST_SU_CMP = 11'b000_0000_0100,
    ST_PO_TOP = 11'b000_0000_1000,
    ST_PO_LST = 11'b000_0001_0000,
    ST_PO_SET = 11'b000_0010_0000,
    ST_SD_RDL = 11'b000_0100_0000,
    ST_SD_RDR = 11'b000_1000_0000,
    ST_SD_SEL = 11'b001_0000_0000,
    ST_SD_CMP = 11'b010_0000_0000,
    ST_DONE   = 11'b100_0000_0000
  } state_e;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [CNT_W-1:0]       idx_q, idx_d;
  logic [CNT_W-1:0]       bidx_q, bidx_d;
  logic signed [KW-1:0]   key_q, key_d;
  logic signed [KW-1:0]   best_q, best_d;
  logic signed [KW-1:0]   top_q, top_d;
  logic [mhpq_pkg::STATUS_W-1:0] status_q, status_d;

  logic                   ram_we;
  logic [CNT_W-1:0]       ram_waddr;
  logic signed [KW-1:0]   ram_wdata;
  logic [CNT_W-1:0]       ram_raddr;
  logic signed [KW-1:0]   ram_rdata;
  logic signed [KW-1:0]   cmp_a;
  logic signed [KW-1:0]   cmp_b;
  logic                   cmp_gt;

  logic [CNT_W:0]         child_l;
  logic [CNT_W:0]         child_r;
  logic [CNT_W:0]         cnt_wide;
  logic [CNT_W+7:0]       cnt_ext;

  assign child_l  = {idx_q, 1'b0};
  assign child_r  = {idx_q, 1'b1};
  assign cnt_wide = {1'b0, cnt_q};
  assign cnt_ext  = {8'd0, cnt_q};

  mhpq_ram #(
    .WIDTH (KW),
    .DEPTH (CAPACITY + 1)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mhpq_cmp u_cmp (
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .gt_o (cmp_gt)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    bidx_d      = bidx_q;
    key_d       = key_q;
    best_d      = best_q;
    top_d       = top_q;
    status_d    = status_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = key_q;
    ram_raddr   = '0;
    cmp_a       = key_q;
    cmp_b       = ram_rdata;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          status_d = mhpq_pkg::STATUS_OK;
          top_d    = '0;
          if (req_type_i == mhpq_pkg::REQ_PUSH) begin
            if (cnt_q == CAP_CNT) begin
              status_d = mhpq_pkg::STATUS_FULL;
              state_d  = ST_DONE;
            end else begin
              cnt_d   = cnt_q + CNT_W'(1);
              idx_d   = cnt_q + CNT_W'(1);
              key_d   = key_in_i;
              state_d = ST_SU_RD;
            end
          end else begin
            if (cnt_q == '0) begin
              status_d = mhpq_pkg::STATUS_EMPTY;
              state_d  = ST_DONE;
            end else begin
              state_d = ST_PO_TOP;
            end
          end
        end
      end
      ST_SU_RD: begin
        if (idx_q == ROOT) begin
          ram_we  = 1'b1;
          state_d = ST_DONE;
        end else begin
          ram_raddr = idx_q >> 1;
          state_d   = ST_SU_CMP;
        end
      end
      ST_SU_CMP: begin
        // parent data arrives now; move it down if the new key beats it
        ram_we = 1'b1;
        if (cmp_gt) begin
          ram_wdata = ram_rdata;
          idx_d     = idx_q >> 1;
          state_d   = ST_SU_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_PO_TOP: begin
        ram_raddr = ROOT;
        state_d   = ST_PO_LST;
      end
      ST_PO_LST: begin
        ram_raddr = cnt_q;
        top_d     = ram_rdata;
        state_d   = ST_PO_SET;
      end
      ST_PO_SET: begin
        key_d   = ram_rdata;
        cnt_d   = cnt_q - CNT_W'(1);
        idx_d   = ROOT;
        state_d = ST_SD_RDL;
      end
      ST_SD_RDL: begin
        if (child_l > cnt_wide) begin
          ram_we  = 1'b1;
          state_d = ST_DONE;
        end else begin
          ram_raddr = child_l[CNT_W-1:0];
          state_d   = ST_SD_RDR;
        end
      end
      ST_SD_RDR: begin
        best_d = ram_rdata;
        bidx_d = child_l[CNT_W-1:0];
        if (child_r <= cnt_wide) begin
          ram_raddr = child_r[CNT_W-1:0];
          state_d   = ST_SD_SEL;
        end else begin
          state_d = ST_SD_CMP;
        end
      end
      ST_SD_SEL: begin
        // right child wins only when strictly larger
        cmp_a = ram_rdata;
        cmp_b = best_q;
        if (cmp_gt) begin
          best_d = ram_rdata;
          bidx_d = child_r[CNT_W-1:0];
        end
        state_d = ST_SD_CMP;
      end
      ST_SD_CMP: begin
        cmp_a  = best_q;
        cmp_b  = key_q;
        ram_we = 1'b1;
        if (cmp_gt) begin
          ram_wdata = best_q;
          idx_d     = bidx_q;
          state_d   = ST_SD_RDL;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o.key_out     = top_q;
  assign res_o.status      = status_q;
  assign res_o.count_after = cnt_ext[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    bidx_q   <= bidx_d;
    key_q    <= key_d;
    best_q   <= best_d;
    top_q    <= top_d;
    status_q <= status_d;
  end

endmodule

FILE: hdl/max_heap_priority_queue.sv
// Binary max-heap priority queue, one request in flight, result in an output register.
// Push sifts the new key up toward the root (0..7 levels climbed at CAPACITY 255);
// pop fetches the root and last key, sifts the last key down, then hands the root over.
// Refused requests (push when full, pop when empty) skip the heap and go straight to the result.
// The next request is taken in the cycle after the output register loads.
// The heap RAM (one read port with registered data, one write port) sets the per-level cost.
// Reset (async, active low) empties the heap; RAM contents are not cleared.
module max_heap_priority_queue #(
  parameter int unsigned CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mhpq_req_if.sink    req_i,
  mhpq_rsp_if.source  rsp_o
);

  logic              res_valid;
  logic              res_ready;
  mhpq_pkg::result_t res;
  mhpq_pkg::result_t out_q;
  logic              out_valid_q;

  mhpq_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_type_i  (req_i.req_type),
    .key_in_i    (req_i.key_in),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register frees up in the same cycle its transaction completes
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.key_out     = out_q.key_out;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.count_after = out_q.count_after;

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for max_heap_priority_queue: push/pop transactions checked
// against a behavioural heap held in a small scoreboard class.
// Depends on mhpq_pkg, mhpq_req_if, mhpq_rsp_if and the max_heap_priority_queue RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned KEY_W        = mhpq_pkg::KEY_W;
  localparam int unsigned COUNT_W      = mhpq_pkg::COUNT_W;
  localparam int unsigned HEAP_DEPTH   = mhpq_pkg::CAPACITY_DEF;
  localparam int unsigned N_ITEMS      = 1900;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned HOLD_AFTER   = 300;
  localparam int unsigned DRAIN_CYCLES = 64;

  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

  // Behavioural max-heap plus the queue of results it still owes.
  class heap_scoreboard;
    logic signed [KEY_W-1:0] slots [1:HEAP_DEPTH];
    int unsigned             fill       = 0;
    int unsigned             checked    = 0;
    int unsigned             mismatches = 0;
    mhpq_pkg::result_t       owed [$];

    function void note_request(logic rtype, logic signed [KEY_W-1:0] key);
      mhpq_pkg::result_t       exp;
      int unsigned             pos;
      int unsigned             child;
      logic signed [KEY_W-1:0] moved;
      exp.key_out = '0;
      exp.status  = mhpq_pkg::STATUS_OK;
      if (rtype == mhpq_pkg::REQ_PUSH) begin
        if (fill >= HEAP_DEPTH) begin
          exp.status = mhpq_pkg::STATUS_FULL;
        end else begin
          fill = fill + 1;
          pos  = fill;
          // sift up; an equal parent stops the climb
          while (pos > 1 && key > slots[pos >> 1]) begin
            slots[pos] = slots[pos >> 1];
            pos = pos >> 1;
          end
          slots[pos] = key;
        end
      end else begin
        if (fill == 0) begin
          exp.status = mhpq_pkg::STATUS_EMPTY;
        end else begin
          exp.key_out = slots[1];
          moved = slots[fill];
          fill  = fill - 1;
          pos   = 1;
          child = 2;
          // sift down toward the larger child, left one on a tie
          while (child <= fill) begin
            if (child < fill && slots[child + 1] > slots[child]) child = child + 1;
            if (!(slots[child] > moved)) break;
            slots[pos] = slots[child];
            pos   = child;
            child = child << 1;
          end
          slots[pos] = moved;
        end
      end
      exp.count_after = COUNT_W'(fill);
      owed.push_back(exp);
    endfunction

    function void check_result(mhpq_pkg::result_t got);
      mhpq_pkg::result_t exp;
      if (owed.size() == 0) begin
        $error("result with nothing outstanding: key_out %0d status %0d count %0d",
               got.key_out, got.status, got.count_after);
        mismatches++;
        return;
      end
      exp = owed.pop_front();
      checked++;
      if (got.key_out !== exp.key_out) begin
        $error("key_out: expected %0d, actual %0d", exp.key_out, got.key_out);
        mismatches++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, got.status);
        mismatches++;
      end
      if (got.count_after !== exp.count_after) begin
        $error("count_after: expected %0d, actual %0d", exp.count_after, got.count_after);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic no_idle_phase;
  int unsigned     items_sent;
  int unsigned     quiet_cycles = 0;
  heap_scoreboard  sb;

  mhpq_req_if req_bus ();
  mhpq_rsp_if rsp_bus ();

  max_heap_priority_queue #(
    .CAPACITY(HEAP_DEPTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic int unsigned draw_gap();
    if (no_idle_phase) return 0;
    return $urandom_range(0, 12);
  endfunction

  // Mostly full-range keys, with clusters of small values for ties and the extremes.
  function automatic logic signed [KEY_W-1:0] rand_key();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5) return $urandom;
    if (sel <= 7) return $signed($urandom_range(0, 8)) - 4;
    case ($urandom_range(0, 3))
      0: return KEY_MAX;
      1: return KEY_MIN;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // Entered at a clock edge; returns at the edge after the idle gap that follows.
  task automatic send_request(logic rtype, logic signed [KEY_W-1:0] key);
    int unsigned gap;
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= rtype;
    req_bus.key_in   <= key;
    do @(posedge clk_i); while (!req_bus.ready);
    sb.note_request(rtype, key);
    items_sent++;
    gap = draw_gap();
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic push_key(logic signed [KEY_W-1:0] key);
    send_request(mhpq_pkg::REQ_PUSH, key);
  endtask

  task automatic pop_max();
    send_request(mhpq_pkg::REQ_POP, rand_key());
  endtask

  // Stall watchdog: any cycle with a transaction on either side clears it.
  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Response side, with one long hold-off to back the queue up into the request side.
  initial begin : rsp_side
    int unsigned       gap;
    bit                held;
    mhpq_pkg::result_t got;
    held = 1'b0;
    rsp_bus.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (!held && sb.checked >= HOLD_AFTER) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end else begin
        gap = draw_gap();
      end
      if (gap > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_bus.valid);
      got.key_out     = rsp_bus.key_out;
      got.status      = rsp_bus.status;
      got.count_after = rsp_bus.count_after;
      sb.check_result(got);
    end
  end

  initial begin : req_side
    int unsigned phase;
    int unsigned sel;
    int unsigned len;
    int unsigned push_pct;
    sb            = new();
    items_sent    = 0;
    no_idle_phase = 1'b0;
    rst_ni           <= 1'b0;
    req_bus.valid    <= 1'b0;
    req_bus.req_type <= mhpq_pkg::REQ_PUSH;
    req_bus.key_in   <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pop, extremes, ties, drain past empty
    pop_max();
    push_key('0);
    push_key(KEY_MAX);
    push_key(KEY_MIN);
    push_key('1);
    push_key(1);
    push_key(5);
    push_key(5);
    push_key(5);
    repeat (8) pop_max();
    pop_max();
    push_key(KEY_MIN);
    push_key(KEY_MIN);
    repeat (3) pop_max();

    // random: fill and drain phases reach the full and empty refusals,
    // mixed phases churn the heap at every depth
    phase = 0;
    while (items_sent < N_ITEMS) begin
      no_idle_phase = ($urandom_range(0, 4) == 0);
      sel = (phase == 0) ? 0 : (phase == 1) ? 2 : $urandom_range(0, 9);
      if (sel <= 1) begin
        while (sb.fill < HEAP_DEPTH) push_key(rand_key());
        repeat ($urandom_range(1, 3)) push_key(rand_key());
      end else if (sel <= 3) begin
        while (sb.fill > 0) pop_max();
        repeat ($urandom_range(1, 3)) pop_max();
      end else begin
        len      = $urandom_range(20, 80);
        push_pct = $urandom_range(30, 70);
        repeat (len) begin
          if ($urandom_range(0, 99) < push_pct) push_key(rand_key());
          else pop_max();
        end
      end
      phase++;
    end

    req_bus.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/mhpq_pkg.sv
hdl/mhpq_req_if.sv
hdl/mhpq_rsp_if.sv
hdl/mhpq_ram.sv
hdl/mhpq_cmp.sv
hdl/mhpq_seq.sv
hdl/max_heap_priority_queue.sv
verif/tb_top.sv
